FILE: design/arpc_pkg.sv
// ARP cache package: table size, widths, item structs, op and register codes
// and controller states. No dependencies.
package arpc_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 48;

  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = CFG_IDX_W'(1);

  typedef enum logic {
    OP_LOOKUP  = 1'b0,
    OP_RECEIVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] ip_in;
    logic [47:0] mac_in;
    logic [15:0] arp_opcode;
    logic [31:0] tgt_ip;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac_out;
    logic        reply_valid;
    logic [31:0] reply_ip;
    logic [47:0] reply_mac;
  } out_item_t;

endpackage

FILE: design/arpc_ifs.sv
// Channel interfaces for the ARP cache: input items, result items and
// configuration writes. Depends on arpc_pkg.
interface arpc_in_if;
  logic               valid;
  logic               ready;
  arpc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arpc_out_if;
  logic                valid;
  logic                ready;
  arpc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arpc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [arpc_pkg::CFG_IDX_W-1:0]     index;
  logic [arpc_pkg::CFG_DAT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/arp_cache_and_responder_top.sv
// ARP cache and responder top level: binding table in two synchronous RAMs,
// sequential scan controller and output register. Depends on arpc_pkg, arpc_ifs.
//
// A receive result goes to res_r at the transfer, then to the output register from
// ST_RESULT. A lookup reads slots from 0 up and stops at the first match; a miss
// reads every filled entry (none when empty). One item at a time: the next transfer
// follows the loading of the result, which waits while the output register holds an
// unaccepted result. Reset (rst_n low, synchronous) empties the table by zeroing the
// fill count and clears own_ip / own_mac; no clearing pass.
module arp_cache_and_responder_top (
  input  logic           clk,
  input  logic           rst_n,
  arpc_in_if.sink        in_if,
  arpc_out_if.source     out_if,
  arpc_cfg_if.sink       cfg_if
);

  // Slots only ever become valid, in ascending order, until the table is
  // full; after that slot 0 is overwritten. So entry k is valid exactly when
  // k < fill_r, and the first free slot is fill_r itself.

  arpc_pkg::state_t    state_r, state_nxt;
  logic [arpc_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [arpc_pkg::CNT_W-1:0] scan_r, scan_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [31:0]         key_r, key_nxt;
  arpc_pkg::out_item_t res_r, res_nxt;
  arpc_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         own_ip_r;
  logic [47:0]         own_mac_r;

  // binding RAMs, one read port (registered) and one write port each
  logic [31:0] ip_mem  [arpc_pkg::ENTRIES];
  logic [47:0] mac_mem [arpc_pkg::ENTRIES];
  logic [31:0] rd_ip_r;
  logic [47:0] rd_mac_r;

  logic                       in_rdy;
  logic                       accept;
  logic                       issue;
  logic                       match;
  logic                       scan_done;
  logic                       deliver;
  logic                       wr_en;
  logic                       full;
  logic [arpc_pkg::IDX_W-1:0] wr_slot;
  logic [arpc_pkg::IDX_W-1:0] rd_addr;

  assign accept  = in_if.valid && in_rdy;
  assign full    = (fill_r == arpc_pkg::CNT_W'(arpc_pkg::ENTRIES));
  assign wr_slot = full ? '0 : fill_r[arpc_pkg::IDX_W-1:0];
  assign rd_addr = scan_r[arpc_pkg::IDX_W-1:0];
  assign match   = rd_pend_r && (rd_ip_r == key_r);
  // nothing in flight and nothing left to read: a miss
  assign scan_done = !rd_pend_r && (scan_r >= fill_r);

  // ---- controller outputs ----
  always_comb begin
    in_rdy  = (state_r == arpc_pkg::ST_IDLE);
    wr_en   = 1'b0;
    issue   = 1'b0;
    deliver = 1'b0;
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        // input is always ready here, so a valid receive is a transfer
        wr_en = in_if.valid && (in_if.data.op == arpc_pkg::OP_RECEIVE);
      end
      arpc_pkg::ST_SCAN: begin
        issue = !match && (scan_r < fill_r);
      end
      arpc_pkg::ST_RESULT: begin
        deliver = !out_valid_r || out_if.ready;
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_if.data.op == arpc_pkg::OP_RECEIVE) state_nxt = arpc_pkg::ST_RESULT;
          else                                       state_nxt = arpc_pkg::ST_SCAN;
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (match || scan_done) state_nxt = arpc_pkg::ST_RESULT;
      end
      arpc_pkg::ST_RESULT: begin
        if (deliver) state_nxt = arpc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- datapath next values ----
  always_comb begin
    fill_nxt    = fill_r;
    scan_nxt    = scan_r;
    key_nxt     = key_r;
    res_nxt     = res_r;
    rd_pend_nxt = issue;
    if (accept) begin
      scan_nxt = '0;
      key_nxt  = in_if.data.ip_in;
      res_nxt  = '0;
      if (in_if.data.op == arpc_pkg::OP_RECEIVE) begin
        if (!full) fill_nxt = fill_r + 1'b1;
        if (in_if.data.arp_opcode == arpc_pkg::ARP_OP_REQUEST &&
            in_if.data.tgt_ip == own_ip_r) begin
          res_nxt.reply_valid = 1'b1;
          res_nxt.reply_ip    = in_if.data.ip_in;
          res_nxt.reply_mac   = in_if.data.mac_in;
        end
      end
    end
    if (issue) scan_nxt = scan_r + 1'b1;
    if (state_r == arpc_pkg::ST_SCAN && match) begin
      res_nxt.hit     = 1'b1;
      res_nxt.mac_out = rd_mac_r;
    end
  end

  // output register: a finished result waits here while the next item runs
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (deliver) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arpc_pkg::ST_IDLE;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      own_ip_r    <= '0;
      own_mac_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        case (cfg_if.index)
          arpc_pkg::CFG_OWN_IP:  own_ip_r  <= cfg_if.data[31:0];
          arpc_pkg::CFG_OWN_MAC: own_mac_r <= cfg_if.data[47:0];
          default: ;  // unknown index: dropped
        endcase
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    key_r  <= key_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // ---- binding RAMs ----
  // Writes happen only on the transfer of a receive item and reads only
  // while scanning a later lookup, so the ports never touch an entry in the
  // same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[wr_slot]  <= in_if.data.ip_in;
      mac_mem[wr_slot] <= in_if.data.mac_in;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ip_r  <= ip_mem[rd_addr];
      rd_mac_r <= mac_mem[rd_addr];
    end
  end

  // ---- ports ----
  assign in_if.ready  = in_rdy;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;
  assign cfg_if.ready = 1'b1;

endmodule
